// File: rtl/srvd_pkg.sv
// Package for the sparse row times dense vector block.
// Holds field widths, codes, the queue item type and default sizes.
// No dependencies.
package srvd_pkg;

    localparam int COL_W            = 10;
    localparam int VAL_W            = 32;
    localparam int ACC_W            = 64;
    localparam int VECTOR_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int CFG_IDX_W        = 1;

    localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_ROW  = 1'b1
    } opcode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SUM_ONLY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_DERV = 1'b1;

    // One classified row element on its way from the front to the back.
    typedef struct packed
    {
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] vec;
        logic             sum_only;
        logic             skip_derv;
        logic             last;
    } srvd_item_t;

endpackage

// File: rtl/sparse_row_vector_dot.sv
// Top level of the sparse row times dense vector block.
// Instantiates srvd_front, srvd_queue and srvd_back; depends on srvd_pkg.
//
//   Channel  Direction  Handshake           Contents
//   s_*      in         s_tvalid/s_tready   load or row element request
//   m_*      out        m_tvalid/m_tready   derivatives and row sum
//   cfg_*    in         cfg_valid/cfg_ready register write
//
// One request is accepted per cycle while s_tready is high. A row element's result
// passes the store read register, a queue slot, the product register and then the
// output register before it shows on m_*.
// The accumulator loop (one saturating 64-bit add) sets the single-cycle rate.
// Reset clears modes, accumulator and queue; the vector store is not cleared.
// A stalled m_tready fills the queue, then s_tready drops; loads keep the front moving.
module sparse_row_vector_dot #(
    parameter int VECTOR_DEPTH = srvd_pkg::VECTOR_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = srvd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // column_index, operand_value, zero pad
    input  logic                           s_tuser,   // opcode
    input  logic                           s_tlast,   // row_last
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [127:0]                   m_tdata,   // matrix_derivative, vector_derivative,
                                                      // row_sum
    output logic                           m_tlast,   // row_done
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);
    import srvd_pkg::*;

    logic             push;
    logic             pop;
    logic             queue_full;
    logic             queue_not_empty;
    srvd_item_t       push_item;
    srvd_item_t       head_item;
    logic [VAL_W-1:0] out_mder;
    logic [VAL_W-1:0] out_vder;
    logic [ACC_W-1:0] out_row_sum;

    assign cfg_ready = 1'b1;

    srvd_front #(
        .VECTOR_DEPTH(VECTOR_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_opcode  (s_tuser),
        .in_col     (s_tdata[COL_W-1:0]),
        .in_value   (s_tdata[COL_W+VAL_W-1:COL_W]),
        .in_last    (s_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    srvd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_item (head_item)
    );

    srvd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (queue_not_empty),
        .q_item       (head_item),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_mder     (out_mder),
        .out_vder     (out_vder),
        .out_row_sum  (out_row_sum),
        .out_row_done (m_tlast)
    );

    assign m_tdata = {out_row_sum, out_vder, out_mder};

endmodule

// File: rtl/srvd_front.sv
// Front end: accepts input requests, keeps the vector store and classifies row elements.
// Depends on srvd_pkg.
module srvd_front #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [srvd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_opcode,
    input  logic [srvd_pkg::COL_W-1:0]     in_col,
    input  logic [srvd_pkg::VAL_W-1:0]     in_value,
    input  logic                           in_last,
    output logic                           push,
    output srvd_pkg::srvd_item_t           push_item,
    input  logic                           queue_full
);
    import srvd_pkg::*;

    localparam int AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam int EXT_W = AW + COL_W + 1;

    logic [VAL_W-1:0] store [VECTOR_DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    logic             sum_only_reg;
    logic             skip_derv_reg;
    logic             f_valid_reg;
    logic             f_row_reg;
    logic             f_in_range_reg;
    logic             f_sum_only_reg;
    logic             f_skip_derv_reg;
    logic             f_last_reg;
    logic [VAL_W-1:0] f_value_reg;

    logic             accept;
    logic             f_advance;
    logic [EXT_W-1:0] col_ext;
    logic [AW-1:0]    addr;
    logic             in_range;

    assign col_ext  = EXT_W'(in_col);
    assign addr     = col_ext[AW-1:0];
    assign in_range = col_ext < EXT_W'(VECTOR_DEPTH);

    // Loads leave the front at once; row elements wait for a queue slot.
    assign f_advance = f_valid_reg && (!f_row_reg || !queue_full);
    assign in_ready  = !f_valid_reg || f_advance;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (accept && (in_opcode == OP_LOAD) && in_range)
        begin
            store[addr] <= in_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= store[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_only_reg  <= 1'b0;
            skip_derv_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SUM_ONLY:  sum_only_reg  <= cfg_data;
                CFG_SKIP_DERV: skip_derv_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (f_advance)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_row_reg       <= (in_opcode == OP_ROW);
            f_in_range_reg  <= in_range;
            f_sum_only_reg  <= sum_only_reg;
            f_skip_derv_reg <= skip_derv_reg;
            f_last_reg      <= in_last;
            f_value_reg     <= in_value;
        end
    end

    assign push = f_valid_reg && f_row_reg && !queue_full;

    always_comb
    begin
        push_item.value     = f_value_reg;
        push_item.vec       = f_in_range_reg ? rdata_reg : '0;
        push_item.sum_only  = f_sum_only_reg;
        push_item.skip_derv = f_skip_derv_reg;
        push_item.last      = f_last_reg;
    end

endmodule

// File: rtl/srvd_queue.sv
// Short queue of classified row elements between the front and the back.
// Depends on srvd_pkg.
module srvd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  srvd_pkg::srvd_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output srvd_pkg::srvd_item_t head_item
);
    import srvd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    srvd_item_t     slots [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: rtl/srvd_back.sv
// Back end: product stage, saturating Q32.32 accumulator and output register.
// Depends on srvd_pkg.
module srvd_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_not_empty,
    input  srvd_pkg::srvd_item_t       q_item,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [srvd_pkg::VAL_W-1:0] out_mder,
    output logic [srvd_pkg::VAL_W-1:0] out_vder,
    output logic [srvd_pkg::ACC_W-1:0] out_row_sum,
    output logic                       out_row_done
);
    import srvd_pkg::*;

    logic                    s1_valid_reg;
    logic signed [ACC_W-1:0] s1_term_reg;
    logic [VAL_W-1:0]        s1_mder_reg;
    logic [VAL_W-1:0]        s1_vder_reg;
    logic                    s1_last_reg;
    logic                    s1_emit_reg;

    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [ACC_W-1:0]        acc_raw;
    logic                    out_valid_reg;
    logic [VAL_W-1:0]        out_mder_reg;
    logic [VAL_W-1:0]        out_vder_reg;
    logic [ACC_W-1:0]        out_row_sum_reg;
    logic                    out_row_done_reg;

    logic                    s1_advance;
    logic signed [VAL_W-1:0] mul_a;
    logic signed [VAL_W-1:0] mul_b;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] widened;

    // A result-free element never waits on the output register.
    assign s1_advance = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || out_ready);
    assign pop        = q_not_empty && (!s1_valid_reg || s1_advance);

    assign mul_a   = q_item.value;
    assign mul_b   = q_item.vec;
    assign product = mul_a * mul_b;
    assign widened = {{(ACC_W - VAL_W - 16){q_item.value[VAL_W-1]}}, q_item.value, 16'h0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_term_reg <= q_item.sum_only ? widened : product;
            s1_last_reg <= q_item.last;
            s1_emit_reg <= !q_item.skip_derv || q_item.last;
            if (q_item.skip_derv)
            begin
                s1_mder_reg <= '0;
                s1_vder_reg <= '0;
            end
            else if (q_item.sum_only)
            begin
                s1_mder_reg <= ONE_Q16;
                s1_vder_reg <= '0;
            end
            else
            begin
                s1_mder_reg <= q_item.vec;
                s1_vder_reg <= q_item.value;
            end
        end
    end

    // Overflow only when both addends share a sign that the sum lost.
    always_comb
    begin
        acc_raw  = acc_reg + s1_term_reg;
        acc_next = acc_raw;
        if ((acc_reg[ACC_W-1] == s1_term_reg[ACC_W-1]) &&
            (acc_raw[ACC_W-1] != acc_reg[ACC_W-1]))
        begin
            acc_next = acc_reg[ACC_W-1] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                        : {1'b0, {(ACC_W - 1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                acc_reg <= s1_last_reg ? '0 : acc_next;
            end
            if (s1_advance && s1_emit_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_emit_reg)
        begin
            out_mder_reg     <= s1_mder_reg;
            out_vder_reg     <= s1_vder_reg;
            out_row_sum_reg  <= s1_last_reg ? acc_next : '0;
            out_row_done_reg <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_mder     = out_mder_reg;
    assign out_vder     = out_vder_reg;
    assign out_row_sum  = out_row_sum_reg;
    assign out_row_done = out_row_done_reg;

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (acc_reg == '0))
        else $error("accumulator not cleared after the last element");
    a_sum_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_row_done_reg) |-> (out_row_sum_reg == '0))
        else $error("row sum shown on a result that does not close the row");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !(s1_advance && s1_emit_reg))
        else $error("pending result overwritten");

endmodule
